>>> rtl/dtsd_pkg.sv
// shared types, constants and register codes for the dual template sad detector
package dtsd_pkg;

  // default template depth, handed to the top level parameter
  localparam int TEMPLATE_DEPTH_DEF = 256;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int POS_W      = 32;
  localparam int PLEN_W     = 9;
  localparam int OFFSET_W   = 16;
  localparam int HOLD_W     = 16;
  localparam int IDX_W      = 8;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // saturation ceiling of a difference sum
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // register reset values
  localparam logic [PLEN_W-1:0]   PATTERN_LENGTH_RST  = 9'd227;
  localparam logic [SUM_W-1:0]    THRESHOLD_RST       = 24'd0;
  localparam logic [OFFSET_W-1:0] REPORT_OFFSET_RST   = 16'd30;
  localparam logic [HOLD_W-1:0]   HOLDOFF_WINDOWS_RST = 16'd30000;

  // register index, byte address is 4 times the index
  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_FIRST_THRESH    = 3'd1,
    REG_SECOND_THRESH   = 3'd2,
    REG_REPORT_OFFSET   = 3'd3,
    REG_HOLDOFF_WINDOWS = 3'd4
  } reg_idx_t;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // template select codes
  localparam logic TPL_FIRST  = 1'b0;
  localparam logic TPL_SECOND = 1'b1;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic                       win_shift;
    logic                       tpl_rot;
    logic                       load_first;
    logic                       load_second;
    logic signed [SAMPLE_W-1:0] load_data;
  } cell_ctrl_t;

endpackage

>>> rtl/dtsd_cell.sv
// one chain cell: a window sample and one entry of each template
module dtsd_cell (
  input  logic                                clk,
  input  dtsd_pkg::cell_ctrl_t                ctrl,
  input  logic                                sel,
  input  logic signed [dtsd_pkg::SAMPLE_W-1:0] win_in,
  input  logic signed [dtsd_pkg::SAMPLE_W-1:0] t1_in,
  input  logic signed [dtsd_pkg::SAMPLE_W-1:0] t2_in,
  output logic signed [dtsd_pkg::SAMPLE_W-1:0] win_q,
  output logic signed [dtsd_pkg::SAMPLE_W-1:0] t1_q,
  output logic signed [dtsd_pkg::SAMPLE_W-1:0] t2_q
);
  import dtsd_pkg::*;

  logic signed [SAMPLE_W-1:0] win_r;
  logic signed [SAMPLE_W-1:0] t1_r;
  logic signed [SAMPLE_W-1:0] t2_r;

  // window sample moves one cell toward the head on a shift or rotation
  always_ff @(posedge clk) begin
    if (ctrl.win_shift) begin
      win_r <= win_in;
    end
  end

  // template entries rotate during a scan, or take a direct load
  always_ff @(posedge clk) begin
    if (ctrl.tpl_rot) begin
      t1_r <= t1_in;
      t2_r <= t2_in;
    end else if (sel) begin
      if (ctrl.load_first) begin
        t1_r <= ctrl.load_data;
      end
      if (ctrl.load_second) begin
        t2_r <= ctrl.load_data;
      end
    end
  end

  assign win_q = win_r;
  assign t1_q  = t1_r;
  assign t2_q  = t2_r;

endmodule

>>> rtl/dtsd_sad_acc.sv
// absolute difference and saturating accumulation at the head of the chain
module dtsd_sad_acc (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  logic                                en,
  input  logic signed [dtsd_pkg::SAMPLE_W-1:0] s,
  input  logic signed [dtsd_pkg::SAMPLE_W-1:0] t1,
  input  logic signed [dtsd_pkg::SAMPLE_W-1:0] t2,
  output logic [dtsd_pkg::SUM_W-1:0]           sum1,
  output logic [dtsd_pkg::SUM_W-1:0]           sum2
);
  import dtsd_pkg::*;

  logic signed [SAMPLE_W:0] diff1;
  logic signed [SAMPLE_W:0] diff2;
  logic [SAMPLE_W-1:0]      ad1_nxt;
  logic [SAMPLE_W-1:0]      ad2_nxt;
  logic [SAMPLE_W-1:0]      ad1_r;
  logic [SAMPLE_W-1:0]      ad2_r;
  logic                     ad_valid_r;
  logic [SUM_W:0]           add1;
  logic [SUM_W:0]           add2;
  logic [SUM_W-1:0]         sum1_nxt;
  logic [SUM_W-1:0]         sum2_nxt;
  logic [SUM_W-1:0]         sum1_r;
  logic [SUM_W-1:0]         sum2_r;

  // stage one: template minus sample, magnitude fits the sample width
  always_comb begin
    diff1   = (SAMPLE_W+1)'(t1) - (SAMPLE_W+1)'(s);
    diff2   = (SAMPLE_W+1)'(t2) - (SAMPLE_W+1)'(s);
    ad1_nxt = diff1[SAMPLE_W] ? SAMPLE_W'(-diff1) : SAMPLE_W'(diff1);
    ad2_nxt = diff2[SAMPLE_W] ? SAMPLE_W'(-diff2) : SAMPLE_W'(diff2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_valid_r <= 1'b0;
    end else begin
      ad_valid_r <= en && !clear;
    end
  end

  always_ff @(posedge clk) begin
    ad1_r <= ad1_nxt;
    ad2_r <= ad2_nxt;
  end

  // stage two: saturating add into the running sums
  always_comb begin
    add1     = {1'b0, sum1_r} + (SUM_W+1)'(ad1_r);
    add2     = {1'b0, sum2_r} + (SUM_W+1)'(ad2_r);
    sum1_nxt = sum1_r;
    sum2_nxt = sum2_r;
    if (clear) begin
      sum1_nxt = '0;
      sum2_nxt = '0;
    end else if (ad_valid_r) begin
      sum1_nxt = add1[SUM_W] ? SUM_MAX : add1[SUM_W-1:0];
      sum2_nxt = add2[SUM_W] ? SUM_MAX : add2[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sum1_r <= sum1_nxt;
    sum2_r <= sum2_nxt;
  end

  assign sum1 = sum1_r;
  assign sum2 = sum2_r;

endmodule

>>> rtl/dual_template_sad_detector.sv
// top level: config registers, cell chain, sequencer and result register
//
// Sliding-window sum of absolute differences against two stored templates.
// The window and both templates live in a chain of TEMPLATE_DEPTH cells. A
// template load, or a stream sample whose window is not yet full or that is
// swallowed by the holdoff count, is taken without starting a scan. A sample
// that closes an examined window starts a scan: the window chain and the
// template chains are rotated a full turn past a single absolute-difference
// and accumulate unit at the head cell, so the block is busy through the scan,
// drain and finish states, and longer while the result register waits for a
// previous result to be taken. After a scan both chains are back in their
// original order. The input is not ready during a scan.
module dual_template_sad_detector #(
  parameter int TEMPLATE_DEPTH = dtsd_pkg::TEMPLATE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] sample_value, [23:16] template_index
  input  logic [23:0]                       in_tdata,
  // [0] command, [1] template_select
  input  logic [1:0]                        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] match_position, [55:32] first_sum, [79:56] second_sum
  output logic [79:0]                       out_tdata,
  // [0] first_matched, [1] second_matched
  output logic [1:0]                        out_tuser,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dtsd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [dtsd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [dtsd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import dtsd_pkg::*;

  localparam int LW  = $clog2(TEMPLATE_DEPTH + 1);
  localparam int LCW = (LW > PLEN_W) ? LW + 1 : PLEN_W + 1;
  localparam int CW  = $clog2(2 * TEMPLATE_DEPTH);
  localparam int DW  = $clog2(TEMPLATE_DEPTH);
  localparam int IW  = (DW > IDX_W) ? DW : IDX_W;

  // configuration registers
  logic [PLEN_W-1:0]   pattern_length_r;
  logic [SUM_W-1:0]    first_thresh_r;
  logic [SUM_W-1:0]    second_thresh_r;
  logic [OFFSET_W-1:0] report_offset_r;
  logic [HOLD_W-1:0]   holdoff_windows_r;
  logic                cfg_wr;
  reg_idx_t            cfg_reg;

  // sequencer state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic [POS_W-1:0]    samples_seen_r, samples_seen_nxt;
  logic [HOLD_W-1:0]   holdoff_left_r, holdoff_left_nxt;
  logic [LW-1:0]       fill_r, fill_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_m1_r, out_m2_r;
  logic [SUM_W-1:0]    out_sum1_r, out_sum2_r;

  // datapath helpers
  logic                in_cmd;
  logic                in_sel;
  logic [IDX_W-1:0]    in_idx;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                accept;
  logic                load_ok;
  logic [LCW-1:0]      plen_ext;
  logic [LCW-1:0]      len_sat;
  logic [LW-1:0]       len_eff;
  logic [CW-1:0]       tpl_start;
  logic [CW-1:0]       scan_end;
  logic                win_rot;
  logic                tpl_rot;
  logic                acc_en;
  logic                acc_clear;
  logic                win_shift_in;
  logic                m1, m2;
  logic                out_free;
  logic                emit;
  logic [SUM_W-1:0]    sum1, sum2;
  cell_ctrl_t          ctrl;
  logic [IW-1:0]       idx_ext;

  logic signed [SAMPLE_W-1:0] win_q [TEMPLATE_DEPTH];
  logic signed [SAMPLE_W-1:0] t1_q  [TEMPLATE_DEPTH];
  logic signed [SAMPLE_W-1:0] t2_q  [TEMPLATE_DEPTH];
  logic signed [SAMPLE_W-1:0] win_last_in;

  // input field unpacking
  assign in_sample = in_tdata[15:0];
  assign in_idx    = in_tdata[23:16];
  assign in_cmd    = in_tuser[0];
  assign in_sel    = in_tuser[1];
  assign accept    = in_tvalid && in_tready;
  assign idx_ext   = IW'(in_idx);
  assign load_ok   = (int'(in_idx) < TEMPLATE_DEPTH);

  // configuration writes and reads
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_reg    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r  <= PATTERN_LENGTH_RST;
      first_thresh_r    <= THRESHOLD_RST;
      second_thresh_r   <= THRESHOLD_RST;
      report_offset_r   <= REPORT_OFFSET_RST;
      holdoff_windows_r <= HOLDOFF_WINDOWS_RST;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_PATTERN_LENGTH:  pattern_length_r  <= cfg_pwdata[PLEN_W-1:0];
        REG_FIRST_THRESH:    first_thresh_r    <= cfg_pwdata[SUM_W-1:0];
        REG_SECOND_THRESH:   second_thresh_r   <= cfg_pwdata[SUM_W-1:0];
        REG_REPORT_OFFSET:   report_offset_r   <= cfg_pwdata[OFFSET_W-1:0];
        REG_HOLDOFF_WINDOWS: holdoff_windows_r <= cfg_pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_PATTERN_LENGTH:  cfg_prdata = CFG_DATA_W'(pattern_length_r);
      REG_FIRST_THRESH:    cfg_prdata = CFG_DATA_W'(first_thresh_r);
      REG_SECOND_THRESH:   cfg_prdata = CFG_DATA_W'(second_thresh_r);
      REG_REPORT_OFFSET:   cfg_prdata = CFG_DATA_W'(report_offset_r);
      REG_HOLDOFF_WINDOWS: cfg_prdata = CFG_DATA_W'(holdoff_windows_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // effective length: zero acts as one, clipped to the chain depth
  always_comb begin
    plen_ext = LCW'(pattern_length_r);
    len_sat  = plen_ext;
    if (plen_ext == '0) begin
      len_sat = LCW'(1);
    end else if (plen_ext > LCW'(TEMPLATE_DEPTH)) begin
      len_sat = LCW'(TEMPLATE_DEPTH);
    end
    len_eff = len_sat[LW-1:0];
  end

  // scan phases: window turns first, templates join for the last len steps
  // of the window turn, then finish their own turn alone
  assign tpl_start = CW'(TEMPLATE_DEPTH) - CW'(len_eff);
  assign scan_end  = CW'(2 * TEMPLATE_DEPTH - 1) - CW'(len_eff);
  assign win_rot   = (state_r == ST_SCAN) && (scan_cnt_r < CW'(TEMPLATE_DEPTH));
  assign tpl_rot   = (state_r == ST_SCAN) && (scan_cnt_r >= tpl_start);
  assign acc_en    = win_rot && tpl_rot;

  // match decision and result register space
  assign m1       = sum1 < first_thresh_r;
  assign m2       = sum2 < second_thresh_r;
  assign out_free = !out_valid_r || out_tready;
  assign emit     = (state_r == ST_FINISH) && out_free && (m1 || m2);

  // sequencer next state and counters
  always_comb begin
    state_nxt        = state_r;
    scan_cnt_nxt     = scan_cnt_r;
    samples_seen_nxt = samples_seen_r;
    holdoff_left_nxt = holdoff_left_r;
    fill_nxt         = fill_r;
    in_tready        = 1'b0;
    win_shift_in     = 1'b0;
    acc_clear        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // ready is high here, so a valid sample is a transfer
        if (in_tvalid && in_cmd == CMD_SAMPLE) begin
          win_shift_in     = 1'b1;
          samples_seen_nxt = samples_seen_r + POS_W'(1);
          if (fill_r != LW'(TEMPLATE_DEPTH)) begin
            fill_nxt = fill_r + LW'(1);
          end
          if (fill_nxt >= len_eff) begin
            if (holdoff_left_r != '0) begin
              holdoff_left_nxt = holdoff_left_r - HOLD_W'(1);
            end else begin
              acc_clear    = 1'b1;
              scan_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!(m1 || m2)) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          holdoff_left_nxt = holdoff_windows_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      scan_cnt_r     <= '0;
      samples_seen_r <= '0;
      holdoff_left_r <= '0;
      fill_r         <= '0;
    end else begin
      state_r        <= state_nxt;
      scan_cnt_r     <= scan_cnt_nxt;
      samples_seen_r <= samples_seen_nxt;
      holdoff_left_r <= holdoff_left_nxt;
      fill_r         <= fill_nxt;
    end
  end

  // chain control shared by all cells
  always_comb begin
    ctrl.win_shift   = win_shift_in || win_rot;
    ctrl.tpl_rot     = tpl_rot;
    ctrl.load_first  = accept && (in_cmd == CMD_LOAD) && load_ok && (in_sel == TPL_FIRST);
    ctrl.load_second = accept && (in_cmd == CMD_LOAD) && load_ok && (in_sel == TPL_SECOND);
    ctrl.load_data   = in_sample;
  end

  // new samples enter at the tail, rotation feeds the head back to the tail
  assign win_last_in = (state_r == ST_IDLE) ? in_sample : win_q[0];

  // cell chain, cell 0 is the head
  for (genvar c = 0; c < TEMPLATE_DEPTH; c++) begin : g_cell
    if (c == TEMPLATE_DEPTH - 1) begin : g_tail
      dtsd_cell u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .sel    (idx_ext == IW'(c)),
        .win_in (win_last_in),
        .t1_in  (t1_q[0]),
        .t2_in  (t2_q[0]),
        .win_q  (win_q[c]),
        .t1_q   (t1_q[c]),
        .t2_q   (t2_q[c])
      );
    end else begin : g_body
      dtsd_cell u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .sel    (idx_ext == IW'(c)),
        .win_in (win_q[c+1]),
        .t1_in  (t1_q[c+1]),
        .t2_in  (t2_q[c+1]),
        .win_q  (win_q[c]),
        .t1_q   (t1_q[c]),
        .t2_q   (t2_q[c])
      );
    end
  end

  // difference sums taken at the head cell
  dtsd_sad_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (acc_clear),
    .en    (acc_en),
    .s     (win_q[0]),
    .t1    (t1_q[0]),
    .t2    (t2_q[0]),
    .sum1  (sum1),
    .sum2  (sum2)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_r  <= samples_seen_r - POS_W'(len_eff) + POS_W'(report_offset_r);
      out_m1_r   <= m1;
      out_m2_r   <= m2;
      out_sum1_r <= sum1;
      out_sum2_r <= sum2;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sum2_r, out_sum1_r, out_pos_r};
  assign out_tuser  = {out_m2_r, out_m1_r};

  // scan counter stays inside the pass
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_cnt_r <= scan_end))
    else $error("scan counter ran past the end of the pass");

  // a new result only comes out of the finish step
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result appeared outside the finish step");

  // fill count saturates at the chain depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(TEMPLATE_DEPTH))
    else $error("window fill count exceeded the chain depth");

  // a reported match rearms the holdoff count
  a_holdoff_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (holdoff_left_r == holdoff_windows_r))
    else $error("holdoff count not reloaded after a match");

  // the input stays closed while a scan runs
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !in_tready)
    else $error("input opened during a scan");

endmodule

>>> bench/dtsd_checker.sv
// checker for the dual template sad detector: watches the streams and the register port
module dtsd_checker #(
  parameter int DEPTH = dtsd_pkg::TEMPLATE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [15:0] sample_value, [23:16] template_index
  input  logic [23:0]                     in_tdata,
  // [0] command, [1] template_select
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] match_position, [55:32] first_sum, [79:56] second_sum
  input  logic [79:0]                     out_tdata,
  // [0] first_matched, [1] second_matched
  input  logic [1:0]                      out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dtsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dtsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              pending,
  output int                              errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtsd_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             first_hit;
    logic             second_hit;
    logic [SUM_W-1:0] first_sum;
    logic [SUM_W-1:0] second_sum;
  } match_report_t;

  // register copies
  logic [PLEN_W-1:0]   plen_q;
  logic [SUM_W-1:0]    thr_first_q;
  logic [SUM_W-1:0]    thr_second_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [HOLD_W-1:0]   holdoff_q;

  // window (entry 0 newest), templates and stream counters
  logic signed [SAMPLE_W-1:0] window_q   [DEPTH];
  logic signed [SAMPLE_W-1:0] first_tpl  [DEPTH];
  logic signed [SAMPLE_W-1:0] second_tpl [DEPTH];
  logic [POS_W-1:0]           taken_count;
  logic [HOLD_W-1:0]          skip_left;
  int                         fill_level;

  match_report_t match_queue[$];
  int            fail_count = 0;

  function automatic int active_length();
    int n;
    n = int'(plen_q);
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // shift one sample in and predict the report of the window it closes
  task automatic take_sample(input logic signed [SAMPLE_W-1:0] value);
    int            len;
    int            d1;
    int            d2;
    int unsigned   s1;
    int unsigned   s2;
    match_report_t r;
    for (int k = DEPTH - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = value;
    taken_count = taken_count + 1;
    if (fill_level < DEPTH) fill_level++;
    len = active_length();
    if (fill_level < len) return;
    if (skip_left != 0) begin
      skip_left = skip_left - 1;
      return;
    end
    s1 = 0;
    s2 = 0;
    // oldest window sample lines up with template entry 0
    for (int j = 0; j < len; j++) begin
      d1 = int'(first_tpl[j]) - int'(window_q[len-1-j]);
      d2 = int'(second_tpl[j]) - int'(window_q[len-1-j]);
      s1 = s1 + ((d1 < 0) ? -d1 : d1);
      s2 = s2 + ((d2 < 0) ? -d2 : d2);
      if (s1 > SUM_MAX) s1 = SUM_MAX;
      if (s2 > SUM_MAX) s2 = SUM_MAX;
    end
    r.first_sum  = s1[SUM_W-1:0];
    r.second_sum = s2[SUM_W-1:0];
    r.first_hit  = r.first_sum < thr_first_q;
    r.second_hit = r.second_sum < thr_second_q;
    if (!r.first_hit && !r.second_hit) return;
    r.position = taken_count - POS_W'(len) + POS_W'(offset_q);
    match_queue.push_back(r);
    skip_left = holdoff_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch in %s: expected %0h, got %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // compare one result transfer against the oldest prediction
  task automatic check_report();
    match_report_t want;
    if (match_queue.size() == 0) begin
      $display("%0t unexpected result: expected none, got position %0h sums %0h %0h",
               $time, out_tdata[31:0], out_tdata[55:32], out_tdata[79:56]);
      fail_count++;
      return;
    end
    want = match_queue.pop_front();
    check_field("match_position", want.position, out_tdata[31:0]);
    check_field("first_matched", 32'(want.first_hit), 32'(out_tuser[0]));
    check_field("second_matched", 32'(want.second_hit), 32'(out_tuser[1]));
    check_field("first_sum", 32'(want.first_sum), 32'(out_tdata[55:32]));
    check_field("second_sum", 32'(want.second_sum), 32'(out_tdata[79:56]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      plen_q       = PATTERN_LENGTH_RST;
      thr_first_q  = THRESHOLD_RST;
      thr_second_q = THRESHOLD_RST;
      offset_q     = REPORT_OFFSET_RST;
      holdoff_q    = HOLDOFF_WINDOWS_RST;
      for (int k = 0; k < DEPTH; k++) begin
        window_q[k]   = '0;
        first_tpl[k]  = '0;
        second_tpl[k] = '0;
      end
      taken_count = '0;
      skip_left   = '0;
      fill_level  = 0;
      match_queue.delete();
    end else begin
      // result side first: a result never belongs to the input of the same edge
      if (out_tvalid && out_tready) check_report();

      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_PATTERN_LENGTH:  plen_q       = cfg_pwdata[PLEN_W-1:0];
          REG_FIRST_THRESH:    thr_first_q  = cfg_pwdata[SUM_W-1:0];
          REG_SECOND_THRESH:   thr_second_q = cfg_pwdata[SUM_W-1:0];
          REG_REPORT_OFFSET:   offset_q     = cfg_pwdata[OFFSET_W-1:0];
          REG_HOLDOFF_WINDOWS: holdoff_q    = cfg_pwdata[HOLD_W-1:0];
          default: ;
        endcase
      end

      // input transfer: template load or stream sample
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CMD_LOAD) begin
          if (int'(in_tdata[23:16]) < DEPTH) begin
            if (in_tuser[1] == TPL_SECOND) second_tpl[in_tdata[23:16]] = in_tdata[15:0];
            else first_tpl[in_tdata[23:16]] = in_tdata[15:0];
          end
        end else begin
          take_sample(in_tdata[15:0]);
        end
      end
    end
    pending <= match_queue.size();
    errors  <= fail_count;
  end

endmodule

>>> bench/testbench.sv
// stimulus and verdict for the dual template sad detector
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dtsd_pkg::*;

  localparam int SETTLE_CYCLES = 2 * TEMPLATE_DEPTH_DEF + 3 + 16;
  localparam int DRAIN_LIMIT   = 100000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [79:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    pending;
  int                    errors;

  // idling percentages, changed per phase
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // what the templates hold, so that matching sequences can be built
  logic signed [SAMPLE_W-1:0] tpl_image  [2][TEMPLATE_DEPTH_DEF];
  bit                         tpl_loaded [2][TEMPLATE_DEPTH_DEF];

  int plen_sweep [13] = '{1, 0, 8, 256, 3, 511, 16, 2, 5, 64, 12, 227, 32};

  always #1 clk = ~clk;

  dual_template_sad_detector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dtsd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .errors      (errors)
  );

  // receiver stalls at random
  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic cmd, input logic [15:0] value,
                           input logic sel, input logic [7:0] idx);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {idx, value};
    in_tuser  <= {sel, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_word(input logic sel, input logic [7:0] idx, input logic [15:0] value);
    tpl_image[sel][idx]  = value;
    tpl_loaded[sel][idx] = 1'b1;
    send_item(CMD_LOAD, value, sel, idx);
  endtask

  task automatic send_sample(input logic [15:0] value);
    send_item(CMD_SAMPLE, value, 1'($urandom), 8'($urandom));
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // let every result come out and any scan in flight finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] nudge(input logic signed [15:0] base, input int amp);
    int x;
    x = int'(base) + int'($urandom_range(0, 2 * amp)) - amp;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return 16'(x);
  endfunction

  function automatic logic [SUM_W-1:0] pick_threshold(input int eff);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SUM_MAX;
      default: return SUM_W'($urandom_range(0, eff * 8 + 4));
    endcase
  endfunction

  function automatic int eff_length(input int plen);
    if (plen == 0) return 1;
    if (plen > TEMPLATE_DEPTH_DEF) return TEMPLATE_DEPTH_DEF;
    return plen;
  endfunction

  // new register setting, then every template entry the window will read is loaded if it never was
  task automatic configure(input int plen, input logic [SUM_W-1:0] thr1,
                           input logic [SUM_W-1:0] thr2, input logic [15:0] offset,
                           input logic [15:0] hold, input int mode);
    wait_idle();
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
      default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
    endcase
    write_register(REG_PATTERN_LENGTH, 32'(plen));
    write_register(REG_FIRST_THRESH, 32'(thr1));
    write_register(REG_SECOND_THRESH, 32'(thr2));
    write_register(REG_REPORT_OFFSET, 32'(offset));
    write_register(REG_HOLDOFF_WINDOWS, 32'(hold));
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < eff_length(plen); i++) begin
        if (!tpl_loaded[s][i]) load_word(1'(s), 8'(i), pick_sample());
      end
    end
  endtask

  // mostly noisy copies of a template, with loads and random samples between
  task automatic random_items(input int count, input int eff);
    int sent;
    int pick;
    int amp;
    int t;
    int burst;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        amp = $urandom_range(0, 3);
        t = $urandom_range(0, 1);
        for (int j = 0; j < eff; j++) send_sample(nudge(tpl_image[t][j], amp));
        sent += eff;
      end else if (pick < 75) begin
        load_word(1'($urandom), 8'($urandom), pick_sample());
        sent++;
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) send_sample(pick_sample());
        sent += burst;
      end
    end
  endtask

  initial begin
    int eff;
    logic [15:0] offset;
    logic [15:0] hold;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // short window, extreme templates against extreme samples, no holdoff
    configure(4, SUM_MAX, 24'd70000, 16'd0, 16'd0, 0);
    load_word(TPL_FIRST, 8'd0, 16'h7FFF);
    load_word(TPL_FIRST, 8'd1, 16'h8000);
    load_word(TPL_FIRST, 8'd2, 16'h7FFF);
    load_word(TPL_FIRST, 8'd3, 16'h8000);
    load_word(TPL_SECOND, 8'd0, 16'h8000);
    load_word(TPL_SECOND, 8'd1, 16'h7FFF);
    load_word(TPL_SECOND, 8'd2, 16'h8000);
    load_word(TPL_SECOND, 8'd3, 16'h7FFF);
    // first three samples leave the window short of full
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    // loads in the middle of the stream
    load_word(TPL_SECOND, 8'd255, 16'h0000);
    load_word(TPL_FIRST, 8'd3, 16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    // zero length acts as one, holdoff of two, largest offset
    configure(0, 24'd1, 24'd0, 16'hFFFF, 16'd2, 0);
    repeat (4) send_sample(tpl_image[TPL_FIRST][0]);
    send_sample(16'h8000);

    // sweep of lengths and settings
    for (int p = 0; p < 13; p++) begin
      eff = eff_length(plen_sweep[p]);
      offset = (p == 2) ? 16'hFFFF : 16'($urandom);
      hold = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, eff + 8));
      configure(plen_sweep[p], pick_threshold(eff), pick_threshold(eff), offset, hold, p % 4);
      random_items((eff >= 200) ? 250 : 50, eff);
    end

    // largest holdoff after a sure match
    configure(2, SUM_MAX, pick_threshold(2), 16'($urandom), 16'hFFFF, 3);
    random_items(60, 2);

    in_tvalid <= 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> dual_template_sad_detector.f
rtl/dtsd_pkg.sv
rtl/dtsd_cell.sv
rtl/dtsd_sad_acc.sv
rtl/dual_template_sad_detector.sv
bench/dtsd_checker.sv
bench/testbench.sv
